// ===== rtl/core/jsu_pkg.sv =====
// Shared types, codes and constants for the JSON string unescaper.
package jsu_pkg;

  // Results one source byte can produce at most (held surrogate + 3-byte value)
  localparam int MaxRes = 6;

  // Decoder modes
  localparam logic [2:0] ModeIdle        = 3'd0;
  localparam logic [2:0] ModeBody        = 3'd1;
  localparam logic [2:0] ModeEsc         = 3'd2;
  localparam logic [2:0] ModeHex         = 3'd3;
  localparam logic [2:0] ModeAfterHigh   = 3'd4;
  localparam logic [2:0] ModeAfterHighBs = 3'd5;

  // Result kinds
  localparam logic [1:0] KindData  = 2'd0;
  localparam logic [1:0] KindDone  = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  // Characters of interest
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLowB = 8'h62;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChLowN = 8'h6E;
  localparam logic [7:0] ChLowR = 8'h72;
  localparam logic [7:0] ChLowT = 8'h74;
  localparam logic [7:0] ChLowU = 8'h75;

  // Surrogate prefixes (top six bits of a 16-bit value)
  localparam logic [5:0] HighSurPrefix = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0] LowSurPrefix  = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [20:0] SuppBase     = 21'h10000;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Lead4 = 8'hF0;
  localparam logic [7:0] Utf8Cont  = 8'h80;
  localparam logic [5:0] Utf8Mask  = 6'h3F;

  // Decoder state carried between source bytes
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic [15:0] held;
    logic        held_vld;
  } jsu_state_t;

  // Result list produced by one source byte
  typedef struct packed {
    logic [2:0]                   cnt;
    logic [MaxRes-1:0][1:0]       kind;
    logic [MaxRes-1:0][7:0]       data;
  } jsu_res_t;

endpackage

// ===== rtl/core/jsu_decode.sv =====
// Combinational decode of one source byte: next state and its result list.
module jsu_decode (
  input  jsu_pkg::jsu_state_t cur,
  input  logic [7:0]          byte_in,
  input  logic                end_of_text,
  output jsu_pkg::jsu_state_t nxt,
  output jsu_pkg::jsu_res_t   res
);

  logic        is_quote;
  logic        is_bs;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic        esc_ok;
  logic        esc_u;
  logic [7:0]  esc_val;
  logic [15:0] acc_new;
  logic        acc_is_low;
  logic        acc_is_high;
  logic [20:0] pair_cp;

  // Per-byte control decided in the mode case
  logic        err;
  logic        flush;
  logic        t_raw;
  logic        t_done;
  logic        t_enc;
  logic [7:0]  raw_byte;
  logic [20:0] t_cp;

  // Encoder and tail list
  logic [2:0]       tail_n;
  logic [3:0][1:0]  tk;
  logic [3:0][7:0]  tb;
  logic [2:0][7:0]  fb;
  logic [2:0]       off;

  assign is_quote = (byte_in == jsu_pkg::ChQuote);
  assign is_bs    = (byte_in == jsu_pkg::ChBslash);

  // Hex digit value, either case
  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (byte_in >= 8'h30 && byte_in <= 8'h39) begin
      hex_d = 4'(byte_in - 8'h30);
    end else if (byte_in >= 8'h61 && byte_in <= 8'h66) begin
      hex_d = 4'(byte_in - 8'h57);
    end else if (byte_in >= 8'h41 && byte_in <= 8'h46) begin
      hex_d = 4'(byte_in - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Single-character escapes
  always_comb begin
    esc_ok  = 1'b1;
    esc_u   = 1'b0;
    esc_val = byte_in;
    unique case (byte_in)
      jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChSlash: esc_val = byte_in;
      jsu_pkg::ChLowB: esc_val = 8'h08;
      jsu_pkg::ChLowF: esc_val = 8'h0C;
      jsu_pkg::ChLowN: esc_val = 8'h0A;
      jsu_pkg::ChLowR: esc_val = 8'h0D;
      jsu_pkg::ChLowT: esc_val = 8'h09;
      jsu_pkg::ChLowU: esc_u   = 1'b1;
      default:         esc_ok  = 1'b0;
    endcase
  end

  assign acc_new     = {cur.hex_acc[11:0], hex_d};
  assign acc_is_low  = (acc_new[15:10] == jsu_pkg::LowSurPrefix);
  assign acc_is_high = (acc_new[15:10] == jsu_pkg::HighSurPrefix);
  assign pair_cp     = jsu_pkg::SuppBase + {1'b0, cur.held[9:0], acc_new[9:0]};

  // Mode handling
  always_comb begin
    nxt      = cur;
    err      = 1'b0;
    flush    = 1'b0;
    t_raw    = 1'b0;
    t_done   = 1'b0;
    t_enc    = 1'b0;
    raw_byte = byte_in;
    t_cp     = {5'd0, acc_new};
    if (end_of_text) begin
      err = 1'b1;
    end else begin
      unique case (cur.mode)
        jsu_pkg::ModeBody, jsu_pkg::ModeAfterHigh: begin
          if (cur.mode == jsu_pkg::ModeAfterHigh && is_bs) begin
            nxt.mode = jsu_pkg::ModeAfterHighBs;
          end else begin
            if (cur.mode == jsu_pkg::ModeAfterHigh) begin
              flush        = 1'b1;
              nxt.held     = '0;
              nxt.held_vld = 1'b0;
            end
            if (is_quote) begin
              t_done   = 1'b1;
              nxt      = '0;
              nxt.mode = jsu_pkg::ModeIdle;
            end else if (is_bs) begin
              nxt.mode = jsu_pkg::ModeEsc;
            end else begin
              nxt.mode = jsu_pkg::ModeBody;
              t_raw    = 1'b1;
            end
          end
        end
        jsu_pkg::ModeEsc, jsu_pkg::ModeAfterHighBs: begin
          if (cur.mode == jsu_pkg::ModeAfterHighBs && esc_u) begin
            nxt.mode    = jsu_pkg::ModeHex;
            nxt.hex_acc = '0;
            nxt.hex_cnt = '0;
          end else begin
            if (cur.mode == jsu_pkg::ModeAfterHighBs) begin
              flush        = 1'b1;
              nxt.held     = '0;
              nxt.held_vld = 1'b0;
            end
            if (esc_u) begin
              nxt.mode    = jsu_pkg::ModeHex;
              nxt.hex_acc = '0;
              nxt.hex_cnt = '0;
            end else if (esc_ok) begin
              nxt.mode = jsu_pkg::ModeBody;
              t_raw    = 1'b1;
              raw_byte = esc_val;
            end else begin
              err = 1'b1;
            end
          end
        end
        jsu_pkg::ModeHex: begin
          if (!hex_ok) begin
            err = 1'b1;
          end else if (cur.hex_cnt != 2'd3) begin
            nxt.hex_acc = acc_new;
            nxt.hex_cnt = cur.hex_cnt + 2'd1;
          end else begin
            nxt.hex_acc = '0;
            nxt.hex_cnt = '0;
            if (cur.held_vld && acc_is_low) begin
              // surrogate pair joins into one supplementary code point
              nxt.held     = '0;
              nxt.held_vld = 1'b0;
              nxt.mode     = jsu_pkg::ModeBody;
              t_enc        = 1'b1;
              t_cp         = pair_cp;
            end else begin
              flush = cur.held_vld;
              if (acc_is_high) begin
                nxt.held     = acc_new;
                nxt.held_vld = 1'b1;
                nxt.mode     = jsu_pkg::ModeAfterHigh;
              end else begin
                nxt.held     = '0;
                nxt.held_vld = 1'b0;
                nxt.mode     = jsu_pkg::ModeBody;
                t_enc        = 1'b1;
              end
            end
          end
        end
        default: begin
          // idle and unused codes: wait for the opening quote
          if (is_quote) begin
            nxt      = '0;
            nxt.mode = jsu_pkg::ModeBody;
          end else begin
            err = 1'b1;
          end
        end
      endcase
    end
    if (err) begin
      nxt      = '0;
      nxt.mode = jsu_pkg::ModeIdle;
    end
  end

  // Tail of the list: raw byte, completion, or UTF-8 encoding of t_cp
  always_comb begin
    tk     = {4{jsu_pkg::KindData}};
    tb     = '0;
    tail_n = 3'd0;
    if (t_raw) begin
      tail_n = 3'd1;
      tb[0]  = raw_byte;
    end else if (t_done) begin
      tail_n = 3'd1;
      tk[0]  = jsu_pkg::KindDone;
    end else if (t_enc) begin
      if (t_cp < 21'h80) begin
        tail_n = 3'd1;
        tb[0]  = t_cp[7:0];
      end else if (t_cp < 21'h800) begin
        tail_n = 3'd2;
        tb[0]  = jsu_pkg::Utf8Lead2 | {3'd0, t_cp[10:6]};
        tb[1]  = jsu_pkg::Utf8Cont | {2'd0, t_cp[5:0] & jsu_pkg::Utf8Mask};
      end else if (t_cp < jsu_pkg::SuppBase) begin
        tail_n = 3'd3;
        tb[0]  = jsu_pkg::Utf8Lead3 | {4'd0, t_cp[15:12]};
        tb[1]  = jsu_pkg::Utf8Cont | {2'd0, t_cp[11:6] & jsu_pkg::Utf8Mask};
        tb[2]  = jsu_pkg::Utf8Cont | {2'd0, t_cp[5:0] & jsu_pkg::Utf8Mask};
      end else begin
        tail_n = 3'd4;
        tb[0]  = jsu_pkg::Utf8Lead4 | {5'd0, t_cp[20:18]};
        tb[1]  = jsu_pkg::Utf8Cont | {2'd0, t_cp[17:12] & jsu_pkg::Utf8Mask};
        tb[2]  = jsu_pkg::Utf8Cont | {2'd0, t_cp[11:6] & jsu_pkg::Utf8Mask};
        tb[3]  = jsu_pkg::Utf8Cont | {2'd0, t_cp[5:0] & jsu_pkg::Utf8Mask};
      end
    end
  end

  // Held high surrogate always encodes as three bytes
  assign fb[0] = jsu_pkg::Utf8Lead3 | {4'd0, cur.held[15:12]};
  assign fb[1] = jsu_pkg::Utf8Cont | {2'd0, cur.held[11:6] & jsu_pkg::Utf8Mask};
  assign fb[2] = jsu_pkg::Utf8Cont | {2'd0, cur.held[5:0] & jsu_pkg::Utf8Mask};
  assign off   = flush ? 3'd3 : 3'd0;

  // Assemble flush bytes then tail; an error replaces everything
  always_comb begin
    logic [2:0] j;
    j        = '0;
    res.cnt  = off + tail_n;
    res.kind = {jsu_pkg::MaxRes{jsu_pkg::KindData}};
    res.data = '0;
    for (int k = 0; k < jsu_pkg::MaxRes; k++) begin
      j = 3'(k) - off;
      if (flush && k < 3) begin
        res.data[k] = fb[k];
      end else if (j < tail_n) begin
        res.kind[k] = tk[j[1:0]];
        res.data[k] = tb[j[1:0]];
      end
    end
    if (err) begin
      res.cnt     = 3'd1;
      res.kind    = {jsu_pkg::MaxRes{jsu_pkg::KindData}};
      res.data    = '0;
      res.kind[0] = jsu_pkg::KindError;
    end
  end

endmodule

// ===== rtl/core/json_string_unescape_utf8_top.sv =====
// JSON string unescaper to UTF-8: input register, decode, result buffer.
// Path: an accepted byte is decoded from the input register and moves into
// the result buffer once it is free; its results are offered from there.
// Throughput: one source byte per cycle while each byte yields at most one
// result and out_stall is low; a longer list holds the buffer until drained.
// Reset: synchronous, active low; decoder returns to idle (awaiting quote).
module json_string_unescape_utf8_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_out_byte,
  output logic       out_last_of_run
);

  // Input register
  logic       a_valid_r;
  logic       a_valid_nxt;
  logic [7:0] a_byte_r;
  logic       a_eot_r;

  // Decoder state
  jsu_pkg::jsu_state_t st_r;
  jsu_pkg::jsu_state_t st_nxt;
  jsu_pkg::jsu_res_t   dec_res;

  // Result buffer, entry 0 is on the output
  logic [2:0]                          b_cnt_r;
  logic [2:0]                          b_cnt_nxt;
  logic [jsu_pkg::MaxRes-1:0][1:0]     b_kind_r;
  logic [jsu_pkg::MaxRes-1:0][7:0]     b_data_r;

  logic in_xfer;
  logic out_xfer;
  logic b_free;
  logic a_move;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign b_free   = (b_cnt_r == 3'd0) || (b_cnt_r == 3'd1 && out_xfer);
  assign a_move   = a_valid_r && b_free;
  assign in_stall = a_valid_r && !a_move;

  jsu_decode u_decode (
    .cur        (st_r),
    .byte_in    (a_byte_r),
    .end_of_text(a_eot_r),
    .nxt        (st_nxt),
    .res        (dec_res)
  );

  // Input register control
  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_xfer) begin
      a_valid_nxt = 1'b1;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_byte_r <= in_byte_in;
      a_eot_r  <= in_end_of_text;
    end
  end

  // Decoder state advances when a byte moves into the result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;  // all-zero state is idle with nothing held
    end else if (a_move) begin
      st_r <= st_nxt;
    end
  end

  // Result buffer count
  always_comb begin
    b_cnt_nxt = b_cnt_r;
    if (a_move) begin
      b_cnt_nxt = dec_res.cnt;
    end else if (out_xfer) begin
      b_cnt_nxt = b_cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_cnt_r <= 3'd0;
    end else begin
      b_cnt_r <= b_cnt_nxt;
    end
  end

  // Result buffer entries: load a new list or shift one out
  always_ff @(posedge clk) begin
    if (a_move) begin
      b_kind_r <= dec_res.kind;
      b_data_r <= dec_res.data;
    end else if (out_xfer) begin
      for (int k = 0; k < jsu_pkg::MaxRes - 1; k++) begin
        b_kind_r[k] <= b_kind_r[k+1];
        b_data_r[k] <= b_data_r[k+1];
      end
    end
  end

  assign out_valid       = (b_cnt_r != 3'd0);
  assign out_result_kind = b_kind_r[0];
  assign out_out_byte    = b_data_r[0];
  assign out_last_of_run = (b_cnt_r == 3'd1);

  // Buffer never holds more than one byte's worth of results
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    b_cnt_r <= 3'(jsu_pkg::MaxRes))
    else $error("result buffer count out of range");

  // Draining a multi-result list steps the count down by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && b_cnt_r > 3'd1 |=> b_cnt_r == $past(b_cnt_r) - 3'd1)
    else $error("result buffer drained incorrectly");

  // An error result sends the decoder back to idle with nothing held
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    a_move && dec_res.kind[0] == jsu_pkg::KindError
    |=> st_r.mode == jsu_pkg::ModeIdle && !st_r.held_vld)
    else $error("decoder not idle after error");

  // A held value is always a high surrogate
  a_held_high: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.held_vld |-> st_r.held[15:10] == jsu_pkg::HighSurPrefix)
    else $error("held value is not a high surrogate");

  // Stall toward the source only while a byte waits in the input register
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_valid_r && !b_free)
    else $error("input stalled without a waiting byte");

endmodule
